@@ rtl/core/nmea_rmc_position_extractor_top_assert.svh @@
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor_top_assert.svh
// Assertion macros for the NMEA RMC position extractor.
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_POSITION_EXTRACTOR_TOP_ASSERT_SVH
`define NMEA_RMC_POSITION_EXTRACTOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define NRPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define NRPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/nrpe_pkg.sv @@
// ----------------------------------------------------------------------------
// nrpe_pkg
// Types and constants shared by the NMEA RMC position extractor.
// ----------------------------------------------------------------------------
package nrpe_pkg;

  // Result word kinds
  typedef enum logic [2:0] {
    KIND_LAT      = 3'd0,
    KIND_LAT_HEMI = 3'd1,
    KIND_LON      = 3'd2,
    KIND_LON_HEMI = 3'd3,
    KIND_END      = 3'd4
  } kind_t;

  // Register map (word index = paddr[2])
  localparam logic REG_LAT_INDEX = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  localparam logic [3:0] LAT_INDEX_RESET = 4'd4;
  localparam logic [7:0] LIMIT_RESET     = 8'd100;

  // Characters of interest
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_G       = 8'h47;

  // Sentence end needs more than this many kept bytes
  localparam logic [7:0] END_MIN_POS = 8'd6;

  localparam logic [2:0] HDR_LEN_M1 = 3'd4;
  localparam logic [3:0] FIELD_MAX  = 4'd15;

  // "GPRMC", indexed by match progress
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h47; // G
      3'd1:    ch = 8'h50; // P
      3'd2:    ch = 8'h52; // R
      3'd3:    ch = 8'h4D; // M
      3'd4:    ch = 8'h43; // C
      default: ch = 8'h47;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/nmea_rmc_position_extractor_top.sv @@
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor_top
// Parses an NMEA byte stream and emits the position-field characters of
// each sentence, plus at most one end word per sentence.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall / rx_byte, one received byte per word.
//   Output channel: out_valid / out_stall / item_kind, item_char, sentence_ok.
//   A byte produces zero or one output word: a latitude, hemisphere,
//   longitude or east/west character, or a sentence end word whose
//   sentence_ok flag tells whether GPRMC and both coordinates were seen.
//   A byte passes the input register, then the result register, before its
//   word shows on out_valid. Throughput: one byte per cycle while in_stall is
//   low, set by the update of the sentence state between the two registers,
//   done once per byte.
//   When the receiver stalls, the result register holds its word; the
//   input register still moves on for bytes that give no word, and
//   in_stall rises only when a new word must wait for the held one.
//   Registers over the APB-style port: latitude field index at 0x0
//   (reset 4), sentence limit at 0x4 (reset 100). Write only while idle.
//   Synchronous reset restores both register values and resets the sentence
//   state and valid flags; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_top (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  item_kind,
  output logic [7:0]  item_char,
  output logic        sentence_ok,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "nmea_rmc_position_extractor_top_assert.svh"

  // Configuration registers
  logic [3:0] lat_index;
  logic [7:0] sent_limit;

  // Input register
  logic       in_full;
  logic [7:0] in_byte;

  // Sentence state
  logic [7:0] byte_pos;
  logic [3:0] field_num;
  logic [2:0] hdr_prog;
  logic       hdr_seen;
  logic       lat_present;
  logic       lon_present;
  logic       first_char;
  logic       waiting;

  logic [7:0] byte_pos_next;
  logic [3:0] field_num_next;
  logic [2:0] hdr_prog_next;
  logic       hdr_seen_next;
  logic       lat_present_next;
  logic       lon_present_next;
  logic       first_char_next;
  logic       waiting_next;

  // Per-byte decode
  logic                is_dollar;
  logic                skip;
  logic                keep;
  logic                have_char;
  logic                end_hit;
  logic                res_valid;
  nrpe_pkg::kind_t     res_kind;
  logic [7:0]          res_char;
  logic                res_ok;
  logic                adv;
  logic [4:0]          field;
  logic [4:0]          lat5;
  nrpe_pkg::kind_t     char_kind;

  // Base state after a possible restart
  logic [7:0] cur_pos;
  logic [3:0] cur_field;
  logic [2:0] cur_prog;
  logic       cur_seen;
  logic       cur_lat;
  logic       cur_lon;
  logic       cur_first;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_index  <= nrpe_pkg::LAT_INDEX_RESET;
      sent_limit <= nrpe_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        nrpe_pkg::REG_LAT_INDEX: lat_index  <= pwdata[3:0];
        nrpe_pkg::REG_LIMIT:     sent_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      nrpe_pkg::REG_LAT_INDEX: prdata = {28'd0, lat_index};
      nrpe_pkg::REG_LIMIT:     prdata = {24'd0, sent_limit};
      default:                 prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the input register moves on unless it must hand a word to a
  // full, stalled result register
  // --------------------------------------------------------------------------
  assign adv      = in_full && (!res_valid || !out_valid || !out_stall);
  assign in_stall = in_full && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Sentence parse for the byte in the input register
  // --------------------------------------------------------------------------
  always_comb begin
    is_dollar = (in_byte == nrpe_pkg::CH_DOLLAR);
    skip      = !is_dollar && waiting;

    // a '$' restarts the sentence before the byte itself is handled
    cur_pos   = is_dollar ? 8'd0 : byte_pos;
    cur_field = is_dollar ? 4'd0 : field_num;
    cur_prog  = is_dollar ? 3'd0 : hdr_prog;
    cur_seen  = is_dollar ? 1'b0 : hdr_seen;
    cur_lat   = is_dollar ? 1'b0 : lat_present;
    cur_lon   = is_dollar ? 1'b0 : lon_present;
    cur_first = is_dollar ? 1'b1 : first_char;

    keep  = !skip && (({1'b0, cur_pos} + 9'd1) < {1'b0, sent_limit});
    field = {1'b0, cur_field} + 5'd1;
    lat5  = {1'b0, lat_index};

    byte_pos_next    = keep ? (cur_pos + 8'd1) : cur_pos;
    field_num_next   = cur_field;
    hdr_prog_next    = cur_prog;
    hdr_seen_next    = cur_seen;
    first_char_next  = cur_first;
    have_char        = 1'b0;
    char_kind        = nrpe_pkg::KIND_LAT;

    if (keep) begin
      // header search
      if (in_byte == nrpe_pkg::hdr_char(cur_prog)) begin
        if (cur_prog == nrpe_pkg::HDR_LEN_M1) begin
          hdr_seen_next = 1'b1;
          hdr_prog_next = 3'd0;
        end else begin
          hdr_prog_next = cur_prog + 3'd1;
        end
      end else begin
        hdr_prog_next = (in_byte == nrpe_pkg::CH_G) ? 3'd1 : 3'd0;
      end

      // field numbering and character capture
      if (in_byte == nrpe_pkg::CH_COMMA) begin
        if (cur_field != nrpe_pkg::FIELD_MAX) begin
          field_num_next = cur_field + 4'd1;
        end
        first_char_next = 1'b1;
      end else begin
        if (lat5 != 5'd0) begin
          if (field == lat5) begin
            have_char = 1'b1;
            char_kind = nrpe_pkg::KIND_LAT;
          end else if (field == lat5 + 5'd1 && cur_first) begin
            have_char = 1'b1;
            char_kind = nrpe_pkg::KIND_LAT_HEMI;
          end else if (field == lat5 + 5'd2) begin
            have_char = 1'b1;
            char_kind = nrpe_pkg::KIND_LON;
          end else if (field == lat5 + 5'd3 && cur_first) begin
            have_char = 1'b1;
            char_kind = nrpe_pkg::KIND_LON_HEMI;
          end
        end
        first_char_next = 1'b0;
      end
    end

    // sentence end replaces any character word
    end_hit = !skip && (in_byte == nrpe_pkg::CH_NEWLINE) &&
              (byte_pos_next > nrpe_pkg::END_MIN_POS);

    lat_present_next = cur_lat;
    lon_present_next = cur_lon;
    waiting_next     = is_dollar ? 1'b0 : waiting;
    if (end_hit) begin
      waiting_next = 1'b1;
    end else if (have_char) begin
      if (char_kind == nrpe_pkg::KIND_LAT) lat_present_next = 1'b1;
      if (char_kind == nrpe_pkg::KIND_LON) lon_present_next = 1'b1;
    end

    res_valid = end_hit || have_char;
    res_kind  = end_hit ? nrpe_pkg::KIND_END : char_kind;
    res_char  = end_hit ? 8'd0 : in_byte;
    res_ok    = end_hit && hdr_seen_next && cur_lat && cur_lon;
  end

  // State update for each byte taken from the input register, except bytes skipped while waiting for '$'
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos    <= 8'd0;
      field_num   <= 4'd0;
      hdr_prog    <= 3'd0;
      hdr_seen    <= 1'b0;
      lat_present <= 1'b0;
      lon_present <= 1'b0;
      first_char  <= 1'b1;
      waiting     <= 1'b0;
    end else if (adv && !skip) begin
      byte_pos    <= byte_pos_next;
      field_num   <= field_num_next;
      hdr_prog    <= hdr_prog_next;
      hdr_seen    <= hdr_seen_next;
      lat_present <= lat_present_next;
      lon_present <= lon_present_next;
      first_char  <= first_char_next;
      waiting     <= waiting_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      item_kind   <= res_kind;
      item_char   <= res_char;
      sentence_ok <= res_ok;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NRPE_ASSERT_NEXT(a_end_sets_wait, adv && end_hit, waiting,
    "sentence end did not arm the wait for '$'")
  `NRPE_ASSERT_NOW(a_hdr_prog_range, 1'b1, hdr_prog <= nrpe_pkg::HDR_LEN_M1,
    "header match progress out of range")
  `NRPE_ASSERT_NOW(a_char_no_ok, out_valid && item_kind != nrpe_pkg::KIND_END,
    !sentence_ok, "character word carries sentence_ok")
  `NRPE_ASSERT_NEXT(a_wait_holds, adv && skip, $stable(byte_pos) && waiting,
    "ignored byte changed sentence state")

endmodule

@@ tb/sv/nmea_rmc_position_extractor_top_tb.sv @@
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor_top_tb
// Self-checking bench for the NMEA RMC position extractor. A behavioral
// tracker of the sentence state predicts the output words for every accepted
// byte. Directed sentences come first, then random NMEA-like traffic over
// several register settings and idle/stall mixes.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;
  localparam logic [39:0] RMC_TAG = "GPRMC";

  typedef struct packed {
    nrpe_pkg::kind_t kind;
    logic [7:0]      ch;
    logic            ok;
  } pos_word_t;

  // DUT ports
  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  item_kind;
  logic [7:0]  item_char;
  logic        sentence_ok;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Bench bookkeeping
  pos_word_t pending_words[$];
  int        mismatch_count = 0;
  int        bytes_sent     = 0;
  int        idle_cycles    = 0;
  int        send_idle_pct  = 0;
  int        stall_pct      = 0;

  // Tracker copy of registers and sentence state
  logic [3:0] lat_idx    = nrpe_pkg::LAT_INDEX_RESET;
  logic [7:0] limit      = nrpe_pkg::LIMIT_RESET;
  logic [7:0] pos;
  logic [3:0] fld;
  logic [2:0] hdr_prog;
  logic       hdr_seen, lat_got, lon_got, first_char, wait_dollar;

  nmea_rmc_position_extractor_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .item_kind(item_kind), .item_char(item_char), .sentence_ok(sentence_ok),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- tracker
  function automatic void clear_sentence();
    pos         = 8'd0;
    fld         = 4'd0;
    hdr_prog    = 3'd0;
    hdr_seen    = 1'b0;
    lat_got     = 1'b0;
    lon_got     = 1'b0;
    first_char  = 1'b1;
    wait_dollar = 1'b0;
  endfunction

  // Advance the sentence state by one byte, queue the word it yields
  function automatic void track_sentence(input logic [7:0] c);
    int              fnum;
    int              lat;
    logic            hit;
    nrpe_pkg::kind_t k;
    pos_word_t       w;
    hit = 1'b0;
    k   = nrpe_pkg::KIND_LAT;
    if (c == nrpe_pkg::CH_DOLLAR) clear_sentence();
    else if (wait_dollar) return;

    // only bytes below the limit are parsed
    if (int'(pos) + 1 < int'(limit)) begin
      fnum = int'(fld) + 1;
      lat  = int'(lat_idx);
      pos  = pos + 8'd1;
      if (c == RMC_TAG[8*(4 - int'(hdr_prog)) +: 8]) begin
        hdr_prog = hdr_prog + 3'd1;
        if (hdr_prog >= 3'd5) begin
          hdr_seen = 1'b1;
          hdr_prog = 3'd0;
        end
      end else begin
        hdr_prog = (c == nrpe_pkg::CH_G) ? 3'd1 : 3'd0;
      end
      if (c == nrpe_pkg::CH_COMMA) begin
        if (fld < nrpe_pkg::FIELD_MAX) fld = fld + 4'd1;
        first_char = 1'b1;
      end else begin
        if (lat != 0 && fnum == lat) begin
          hit = 1'b1; k = nrpe_pkg::KIND_LAT;
        end else if (lat != 0 && fnum == lat + 1 && first_char) begin
          hit = 1'b1; k = nrpe_pkg::KIND_LAT_HEMI;
        end else if (lat != 0 && fnum == lat + 2) begin
          hit = 1'b1; k = nrpe_pkg::KIND_LON;
        end else if (lat != 0 && fnum == lat + 3 && first_char) begin
          hit = 1'b1; k = nrpe_pkg::KIND_LON_HEMI;
        end
        first_char = 1'b0;
      end
    end

    // end word wins over any character word
    if (c == nrpe_pkg::CH_NEWLINE && pos > nrpe_pkg::END_MIN_POS) begin
      w.kind = nrpe_pkg::KIND_END;
      w.ch   = 8'h00;
      w.ok   = hdr_seen && lat_got && lon_got;
      pending_words.push_back(w);
      wait_dollar = 1'b1;
      return;
    end
    if (hit) begin
      if (k == nrpe_pkg::KIND_LAT) lat_got = 1'b1;
      if (k == nrpe_pkg::KIND_LON) lon_got = 1'b1;
      w.kind = k;
      w.ch   = c;
      w.ok   = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------- drivers
  // One input word, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_sentence(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  // Stop sending, wait for all expected words plus pipeline slack
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == nrpe_pkg::REG_LAT_INDEX) lat_idx = val[3:0];
    else limit = val;
  endtask

  // Receiver stall pattern
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin : check_words
    pos_word_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: kind %0d char %02h ok %0b",
               item_kind, item_char, sentence_ok);
        mismatch_count++;
      end else begin
        w = pending_words.pop_front();
        if (item_kind !== w.kind) begin
          $error("item_kind: expected %0d, got %0d", w.kind, item_kind);
          mismatch_count++;
        end
        if (item_char !== w.ch) begin
          $error("item_char: expected %02h, got %02h", w.ch, item_char);
          mismatch_count++;
        end
        if (sentence_ok !== w.ok) begin
          $error("sentence_ok: expected %0b, got %0b", w.ok, sentence_ok);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic logic [7:0] field_char();
    string pool;
    pool = "0123456789.NSEWA";
    if ($urandom_range(99) < 10) return 8'($urandom_range(255));
    return pool[$urandom_range(15)];
  endfunction

  // NMEA-like sentence with random header, field count and content
  task automatic send_sentence();
    int nf;
    int flen;
    int r;
    send_byte(nrpe_pkg::CH_DOLLAR);
    r = $urandom_range(99);
    if (r < 75)      send_text("GPRMC");
    else if (r < 85) send_text("GPGGA");
    else if (r < 92) send_text("GGPRMGPRMC");
    else             send_text("GPRM");
    if ($urandom_range(99) < 70) nf = int'(lat_idx) + $urandom_range(0, 4);
    else nf = $urandom_range(0, 20);
    for (int i = 0; i < nf; i++) begin
      send_byte(nrpe_pkg::CH_COMMA);
      flen = ($urandom_range(99) < 25) ? 0 : $urandom_range(1, 8);
      for (int j = 0; j < flen; j++) send_byte(field_char());
    end
    // truncated sentence, next '$' restarts
    if ($urandom_range(99) < 8) return;
    if ($urandom_range(99) < 50) send_byte(8'h0D);
    send_byte(nrpe_pkg::CH_NEWLINE);
  endtask

  // Reset config: noise before any '$', full sentence, ignored tail,
  // short newline, newline taken as a latitude char, empty fields
  task automatic test_directed_sentences();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("$GPRMC,,,1,N,2,E\n");
    send_byte(8'h5A);
    send_text("$\n$,,,\n");
    send_text("$GPRMC,,,,NS,,EW\n");
  endtask

  // Latitude in field one and the smallest buffer: header chars are
  // emitted, later bytes dropped, newline still ends the sentence
  task automatic test_small_buffer();
    write_reg(nrpe_pkg::REG_LAT_INDEX, 8'd1);
    write_reg(nrpe_pkg::REG_LIMIT, 8'd8);
    send_text("$GPRMC,1,N,2,E\n");
    send_text("$$GP,,,,,,,,,,,,,,,,,,9\n");
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct,
                                     input int stl_pct, input logic [7:0] lat,
                                     input logic [7:0] lim);
    int start;
    int next_pause;
    write_reg(nrpe_pkg::REG_LAT_INDEX, lat);
    write_reg(nrpe_pkg::REG_LIMIT, lim);
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    start         = bytes_sent;
    next_pause    = bytes_sent + 120;
    while (bytes_sent - start < n) begin
      if ($urandom_range(99) < 85) begin
        send_sentence();
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
      end
      // let the output side empty completely now and then
      if (bytes_sent >= next_pause) begin
        wait_drained();
        next_pause = bytes_sent + 120;
      end
    end
  endtask

  initial begin
    clear_sentence();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_sentences();
    test_small_buffer();
    test_random_traffic(330, 0, 0, 8'd4, 8'd100);
    test_random_traffic(330, 50, 0, 8'd12, 8'd255);
    test_random_traffic(330, 0, 50, 8'd1, 8'd8);
    test_random_traffic(330, 8, 8, 8'($urandom_range(1, 12)),
                        8'($urandom_range(8, 255)));

    wait_drained();
    repeat (8) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ nmea_rmc_position_extractor_top.f @@
+incdir+rtl/core
rtl/core/nrpe_pkg.sv
rtl/core/nmea_rmc_position_extractor_top.sv
tb/sv/nmea_rmc_position_extractor_top_tb.sv
